[rtl/kslpd_pkg.sv]
// Shared types and constants for the key short/long press detector.
// Used by kslpd_key_cell and key_short_long_press_detector_top; no dependencies.
`default_nettype none

package kslpd_pkg;

  // Sizes
  localparam int unsigned NumKeys    = 4;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned LevelWidth = 4;
  localparam int unsigned ThrWidth   = 16;
  localparam int unsigned CodeWidth  = 4;
  localparam int unsigned IdxWidth   = $clog2((NumKeys > 1) ? NumKeys : 2);
  // Width wide enough to compare a hold count with the threshold
  localparam int unsigned CmpWidth   = (CountWidth > ThrWidth) ? CountWidth : ThrWidth;

  localparam logic [ThrWidth-1:0] ThrReset = ThrWidth'(200);

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ThrWidth-1:0]   thr_t;
  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [CodeWidth-1:0]  code_t;
  typedef logic [IdxWidth-1:0]   key_idx_t;
  typedef logic [CmpWidth-1:0]   cmp_t;

  // Per-key result of one scan tick, before the priority walk
  typedef struct packed {
    logic   short_ev;
    logic   long_ev;
    count_t count_next;
  } key_res_t;

endpackage

`default_nettype wire

[rtl/kslpd_key_cell.sv]
// One key's press evaluation for a scan tick: next hold count and events.
// Depends on kslpd_pkg.
`default_nettype none

module kslpd_key_cell (
  input  logic              pressed_i,
  input  logic              prev_i,
  input  kslpd_pkg::count_t count_i,
  input  kslpd_pkg::thr_t   thr_i,
  output kslpd_pkg::key_res_t res_o
);
  import kslpd_pkg::*;

  count_t inc;
  cmp_t   cnt_x;
  cmp_t   inc_x;
  cmp_t   thr_x;

  // Saturating increment
  assign inc   = (count_i == '1) ? count_i : count_i + count_t'(1);
  assign cnt_x = CmpWidth'(count_i);
  assign inc_x = CmpWidth'(inc);
  assign thr_x = CmpWidth'(thr_i);

  always_comb begin
    res_o.short_ev   = 1'b0;
    res_o.long_ev    = 1'b0;
    res_o.count_next = '0;
    if (pressed_i && prev_i) begin
      // still held: count up, long press only when landing on the threshold
      res_o.count_next = inc;
      res_o.long_ev    = (inc_x == thr_x) && (cnt_x != thr_x);
    end else if (!pressed_i && prev_i && (cnt_x < thr_x)) begin
      // early release: short press, count kept until next released tick
      res_o.short_ev   = 1'b1;
      res_o.count_next = count_i;
    end
  end

endmodule

`default_nettype wire

[rtl/key_short_long_press_detector_top.sv]
// Key short/long press detector: one event code per scan tick.
// Input register -> key evaluation -> result register; one item per cycle sustained
// while the result channel does not stall.
// Reset (async, active low) releases all keys, clears hold counts and both
// valid stages, and loads the long-press threshold with 200.
// Depends on kslpd_pkg and kslpd_key_cell.
`default_nettype none

module key_short_long_press_detector_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  kslpd_pkg::thr_t   cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kslpd_pkg::level_t key_levels_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kslpd_pkg::code_t  event_code_o
);
  import kslpd_pkg::*;

  thr_t     thr_q;
  logic     s1_vld_q, s1_vld_d;
  level_t   s1_lvl_q;
  logic     out_vld_q, out_vld_d;
  code_t    code_q, code_d;
  logic     pressed_q [NumKeys];
  logic     pressed_d [NumKeys];
  count_t   count_q [NumKeys];
  count_t   count_d [NumKeys];
  key_res_t res [NumKeys];
  key_idx_t sel_idx;
  logic     sel_long;
  logic     out_free, adv, accept;

  // Handshake: result register frees up when empty or its transfer completes
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign s1_vld_d  = accept ? 1'b1 : (adv ? 1'b0 : s1_vld_q);
  assign out_vld_d = adv ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  // Per-key evaluation; keys beyond the level field read as pressed
  for (genvar k = 0; k < NumKeys; k++) begin : g_key
    if (k < LevelWidth) begin : g_pin
      assign pressed_d[k] = ~s1_lvl_q[k];
    end else begin : g_nopin
      assign pressed_d[k] = 1'b1;
    end
    kslpd_key_cell u_cell (
      .pressed_i (pressed_d[k]),
      .prev_i    (pressed_q[k]),
      .count_i   (count_q[k]),
      .thr_i     (thr_q),
      .res_o     (res[k])
    );
  end

  // Priority walk: first event wins, later keys keep their counts
  always_comb begin
    logic stop;
    stop     = 1'b0;
    code_d   = '0;
    sel_idx  = '0;
    sel_long = 1'b0;
    for (int k = 0; k < NumKeys; k++) begin
      count_d[k] = stop ? count_q[k] : res[k].count_next;
      if (!stop && (res[k].short_ev || res[k].long_ev)) begin
        stop     = 1'b1;
        sel_idx  = IdxWidth'(k);
        sel_long = res[k].long_ev;
        code_d   = res[k].long_ev ? CodeWidth'(k + 1 + NumKeys) : CodeWidth'(k + 1);
      end
    end
  end

  // Control and key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrReset;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pressed_q <= '{default: 1'b0};
      count_q   <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        pressed_q <= pressed_d;
        count_q   <= count_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lvl_q <= key_levels_i;
    end
    if (adv) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_code_o = code_q;

  // Checks
  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("scan result not registered");

  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (int'(code_q) <= 2 * NumKeys))
    else $error("event code out of range");

  a_long_at_thr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && sel_long) |=>
      (CmpWidth'(count_q[$past(sel_idx)]) == CmpWidth'($past(thr_q))))
    else $error("long press count not at threshold");

  a_no_stall_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && out_vld_q))
    else $error("input stalled with free stages");

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for key_short_long_press_detector_top: scan ticks in, one event code out.
// Uses kslpd_pkg for port types and sizes; a local model predicts every event code.

module tb;
  import kslpd_pkg::*;

  localparam int unsigned DrainLimit = 1000;
  localparam int unsigned TailCycles = 6;

  logic   clk_i;
  logic   rst_ni       = 1'b0;
  logic   cfg_we_i     = 1'b0;
  thr_t   cfg_wdata_i  = '0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  level_t key_levels_i = '1;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  code_t  event_code_o;

  key_short_long_press_detector_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_levels_i(key_levels_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_code_o(event_code_o)
  );

  // Model state: threshold, pressed flags and hold counters
  thr_t              thr_q;
  logic [NumKeys-1:0] key_down_q;
  count_t            hold_q [NumKeys];

  code_t pending_events [$];
  int    mismatch_count = 0;
  int    send_idle_pct  = 0;
  int    recv_idle_pct  = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("tb: errors");
    $finish;
  end

  // One scan tick of the detector; updates the model state
  function automatic code_t predict_event(input level_t lv);
    logic [NumKeys-1:0] was_down;
    code_t  code;
    logic   done;
    count_t c;
    count_t n;
    was_down = key_down_q;
    for (int i = 0; i < NumKeys; i++) begin
      // keys past the level field read as pressed
      key_down_q[i] = (i < LevelWidth) ? ~lv[i] : 1'b1;
    end
    code = '0;
    done = 1'b0;
    for (int i = 0; i < NumKeys; i++) begin
      if (!done) begin
        c = hold_q[i];
        if (key_down_q[i]) begin
          if (!was_down[i]) begin
            hold_q[i] = '0;
          end else begin
            n = (c == '1) ? c : c + 1'b1;
            hold_q[i] = n;
            if (cmp_t'(n) == cmp_t'(thr_q) && cmp_t'(c) != cmp_t'(thr_q)) begin
              code = code_t'(i + 1 + NumKeys);
              done = 1'b1;
            end
          end
        end else if (was_down[i] && cmp_t'(c) < cmp_t'(thr_q)) begin
          // short press; counter keeps its value until the next released tick
          code = code_t'(i + 1);
          done = 1'b1;
        end else begin
          hold_q[i] = '0;
        end
      end
    end
    return code;
  endfunction

  // Result side: random stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result side: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    code_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("event_code: expected none, got %0d", event_code_o);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_code_o !== want) begin
          $error("event_code: expected %0d, got %0d", want, event_code_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Send one scan tick and record its predicted event
  task automatic send_levels(input level_t lv);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_levels_i <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_events.push_back(predict_event(lv));
  endtask

  // Wait until every predicted event has arrived or the drain limit runs out, then idle for the tail
  task automatic drain_events();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Threshold write, only with the block idle
  task automatic write_threshold(input thr_t value);
    drain_events();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_q = value;
  endtask

  // Reset threshold: short press on every key, then one long press
  task automatic test_reset_threshold();
    for (int i = 0; i < NumKeys; i++) begin
      send_levels(~level_t'(1 << i));
      send_levels('1);
    end
    repeat (202) send_levels(4'hB);
    send_levels('1);
  endtask

  // Short directed sequences around small thresholds
  task automatic test_directed();
    write_threshold(thr_t'(3));
    send_levels(4'hF);
    repeat (6) send_levels(4'h0);   // all keys held, long presses queue up by index (keys 0 to 2)
    send_levels(4'hF);
    send_levels(4'hF);
    send_levels(4'hC);              // keys 0 and 1 down
    send_levels(4'hF);              // both released: key 1's short press is lost
    send_levels(4'hF);
    send_levels(4'h5);
    send_levels(4'hA);              // press and release in the same tick
    send_levels(4'hF);
    write_threshold(thr_t'(1));
    send_levels(4'hE);
    send_levels(4'hE);              // first held tick is already long
    send_levels(4'hF);
    write_threshold(thr_t'(0));     // zero: no long press, no short press
    repeat (3) send_levels(4'h0);
    send_levels(4'hF);
    send_levels(4'h6);
    send_levels(4'hF);
  endtask

  // Long holds: one long press past the threshold, none when out of reach
  task automatic test_long_hold();
    write_threshold(thr_t'(5));
    send_levels(4'hF);
    repeat (60) send_levels(4'hD);
    send_levels(4'hF);
    write_threshold('1);
    repeat (80) send_levels(4'h7);
    send_levels(4'hF);
  endtask

  // Random hold episodes with noise runs of one to three random ticks
  task automatic random_scan(input int n_items);
    int sent;
    int span;
    int dur;
    level_t lv;
    sent = 0;
    span = (thr_q >= 1 && thr_q <= 40) ? int'(thr_q) : 20;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        lv  = level_t'($urandom_range(15));
        dur = $urandom_range(1, 2 * span + 3);
        repeat (dur) send_levels(lv);
        sent += dur;
      end else begin
        dur = $urandom_range(1, 3);
        repeat (dur) send_levels(level_t'($urandom_range(15)));
        sent += dur;
      end
    end
  endtask

  task automatic test_random(input int per_setting);
    thr_t settings [6];
    settings[0] = thr_t'(1);
    settings[1] = thr_t'(2);
    settings[2] = thr_t'($urandom_range(3, 12));
    settings[3] = thr_t'($urandom_range(13, 40));
    settings[4] = thr_t'(0);
    settings[5] = '1;
    for (int k = 0; k < 6; k++) begin
      write_threshold(settings[k]);
      random_scan(per_setting);
    end
  endtask

  // Main sequence
  initial begin
    thr_q      = ThrReset;
    key_down_q = '0;
    for (int i = 0; i < NumKeys; i++) hold_q[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(13, 47);
    test_reset_threshold();
    test_directed();
    test_random(90);

    set_idling(47, 13);
    test_random(90);

    set_idling(0, 0);
    test_random(90);
    test_long_hold();

    drain_events();
    if (pending_events.size() != 0) begin
      $error("event_code: %0d predicted events never arrived", pending_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
